// ===== src/bllca_pkg.sv =====
// Package with the command and status codes and field widths of the ancestor query core.
`default_nettype none

package bllca_pkg;

   // Field widths of the stream words.
   localparam int NodeW    = 10;
   localparam int CmdW     = 2;
   localparam int StatusW  = 2;
   localparam int ReqDataW = 40;
   localparam int RspDataW = 16;

   // The root of the tree.
   localparam int RootNode = 1;

   // Commands carried on the request side.
   typedef enum logic [CmdW-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Status codes of the response.
   localparam logic [StatusW-1:0] ST_OK        = 2'd0;
   localparam logic [StatusW-1:0] ST_NOT_BUILT = 2'd1;
   localparam logic [StatusW-1:0] ST_DETACHED  = 2'd2;

endpackage

`default_nettype wire

// ===== src/binary_lifting_lca_core.sv =====
// Lowest common ancestor core: parent, depth and jump memories with a sequencer for build and query.
//
//   Channel | Direction | Handshake             | Contents
//   req     | in        | req_tvalid/req_tready | command in tuser, nodes in tdata
//   rsp     | out       | rsp_tvalid/rsp_tready | status in tuser, ancestor in tdata
//
// After reset the parent memory is swept to "no parent", with req_tready low.
// A load or an unused command is answered from the idle state. A query ends with a detached status
// when a node is detached, else it lifts the deeper node by whole top levels and by the bits of the
// depth difference, climbs both nodes from the top level down and ends with single parent steps.
// A build marks the root, relaxes the depths in passes over every node (at most tree depth plus one
// passes), fills level zero of the jump memory and then every higher level, with one memory access
// chain per node.
// One word is handled at a time; the response register frees the request side once taken.
`default_nettype none

module binary_lifting_lca_core #(
   parameter int MAX_NODES  = 1024,
   parameter int LOG_LEVELS = 10
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   output logic                            req_tready,
   // tdata: child_node[9:0], parent_node[19:10], query_a[29:20], query_b[39:30]
   input  wire  [bllca_pkg::ReqDataW-1:0]  req_tdata,
   // tuser: cmd[1:0]
   input  wire  [bllca_pkg::CmdW-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   // tdata: ancestor_node[9:0], zeros above
   output logic [bllca_pkg::RspDataW-1:0]  rsp_tdata,
   // tuser: status[1:0]
   output logic [bllca_pkg::StatusW-1:0]   rsp_tuser
);
   import bllca_pkg::*;

   localparam int IW       = $clog2(MAX_NODES);
   localparam int LW       = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
   localparam int TOP      = LOG_LEVELS - 1;
   localparam int JT_DEPTH = LOG_LEVELS * (2 ** IW);

   typedef struct packed {
      logic          none;
      logic [IW-1:0] node;
   } ent_type;

   typedef struct packed {
      logic          known;
      logic [IW-1:0] depth;
   } dent_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_INIT, S_R0, S_R1, S_R2, S_Z0, S_Z1, S_J0, S_J1, S_J2,
      S_Q1, S_Q2, S_Q3, S_LT, S_LTW, S_LB, S_LBW, S_CMP, S_CL, S_CLW, S_FIN, S_FINW
   } state_type;

   localparam ent_type NONE = '{none: 1'b1, node: '0};

   // Memories and their registered read data.
   ent_type  par_mem [0:MAX_NODES-1];
   dent_type dep_mem [0:MAX_NODES-1];
   ent_type  jt_mem  [0:JT_DEPTH-1];
   ent_type  par_q, jt_qa, jt_qb;
   dent_type dep_q;

   logic            par_we, dep_we, jt_we;
   logic [IW-1:0]   par_wa, par_ra, dep_wa, dep_ra;
   ent_type         par_wd, jt_wd;
   dent_type        dep_wd;
   logic [LW+IW-1:0] jt_wa, jt_ra_a, jt_ra_b;

   state_type          state_ff;
   logic [IW-1:0]      idx_ff, a_ff, b_ff, d_ff, da_ff;
   logic [LW-1:0]      lvl_ff;
   logic               changed_ff, built_ff;
   logic               rsp_valid_ff;
   logic [NodeW-1:0]   anc_ff;
   logic [StatusW-1:0] status_ff;

   // Request decode.
   cmd_type          req_cmd;
   logic [NodeW-1:0] req_child, req_parent, req_qa, req_qb;
   logic             req_accept, load_ok, query_range_ok;
   logic             last_node, last_level, relax_more, conn_a, conn_b, lift_big, lift_bit;
   logic [LW-1:0]    lvl_prev;

   assign req_cmd    = cmd_type'(req_tuser);
   assign req_child  = req_tdata[NodeW-1:0];
   assign req_parent = req_tdata[2*NodeW-1:NodeW];
   assign req_qa     = req_tdata[3*NodeW-1:2*NodeW];
   assign req_qb     = req_tdata[4*NodeW-1:3*NodeW];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign load_ok = (32'(req_child) < MAX_NODES) && (32'(req_parent) < MAX_NODES)
                    && (32'(req_child) != RootNode);
   assign query_range_ok = (32'(req_qa) < MAX_NODES) && (32'(req_qb) < MAX_NODES);

   assign last_node  = (32'(idx_ff) == MAX_NODES - 1);
   assign last_level = (32'(lvl_ff) == TOP);
   assign lvl_prev   = LW'(lvl_ff - LW'(1));
   assign relax_more = changed_ff || dep_q.known;
   assign conn_a     = (32'(a_ff) == RootNode) || !jt_qa.none;
   assign conn_b     = (32'(b_ff) == RootNode) || !jt_qb.none;
   assign lift_big   = (32'(d_ff) >= (32'd1 << TOP));
   assign lift_bit   = ((32'(d_ff) >> lvl_ff) & 32'd1) != 32'd0;

   // Memory addresses and write enables follow the sequencer state.
   always_comb begin
      par_we  = 1'b0;
      par_wa  = idx_ff;
      par_wd  = NONE;
      par_ra  = idx_ff;
      dep_we  = 1'b0;
      dep_wa  = idx_ff;
      dep_wd  = '{known: 1'b0, depth: '0};
      dep_ra  = idx_ff;
      jt_we   = 1'b0;
      jt_wa   = {lvl_ff, idx_ff};
      jt_wd   = NONE;
      jt_ra_a = {lvl_ff, a_ff};
      jt_ra_b = {lvl_ff, b_ff};
      unique case (state_ff)
         S_CLEAR: begin
            par_we = 1'b1;
         end
         S_IDLE: begin
            par_we = req_accept && (req_cmd == CMD_LOAD) && load_ok;
            par_wa = IW'(req_child);
            par_wd = '{none: 1'b0, node: IW'(req_parent)};
         end
         S_INIT: begin
            dep_we = 1'b1;
            dep_wd = '{known: (32'(idx_ff) == RootNode), depth: '0};
         end
         S_R1: begin
            dep_ra = par_q.node;
         end
         S_R2: begin
            dep_we = dep_q.known;
            dep_wd = '{known: 1'b1, depth: IW'(dep_q.depth + IW'(1))};
         end
         S_Z1: begin
            jt_we = 1'b1;
            jt_wa = {LW'(0), idx_ff};
            if (dep_q.known && (32'(idx_ff) != RootNode) && !par_q.none) begin
               jt_wd = par_q;
            end
         end
         S_J0: begin
            jt_ra_a = {lvl_prev, idx_ff};
         end
         S_J1: begin
            jt_ra_a = {lvl_prev, jt_qa.node};
            jt_we   = jt_qa.none;
         end
         S_J2: begin
            jt_we = 1'b1;
            jt_wd = jt_qa;
         end
         S_Q1: begin
            jt_ra_a = {LW'(0), a_ff};
            jt_ra_b = {LW'(0), b_ff};
            dep_ra  = a_ff;
         end
         S_Q2: begin
            dep_ra = b_ff;
         end
         S_LT: begin
            jt_ra_b = {LW'(TOP), b_ff};
         end
         S_FIN: begin
            jt_ra_a = {LW'(0), a_ff};
            jt_ra_b = {LW'(0), b_ff};
         end
         default: begin
         end
      endcase
   end

   // Parent memory.
   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_wa] <= par_wd;
      end
      par_q <= par_mem[par_ra];
   end

   // Depth memory, with a flag for nodes already reached from the root.
   always_ff @(posedge clock) begin
      if (dep_we) begin
         dep_mem[dep_wa] <= dep_wd;
      end
      dep_q <= dep_mem[dep_ra];
   end

   // Jump memory, one write port and two read ports.
   always_ff @(posedge clock) begin
      if (jt_we) begin
         jt_mem[jt_wa] <= jt_wd;
      end
      jt_qa <= jt_mem[jt_ra_a];
      jt_qb <= jt_mem[jt_ra_b];
   end

   // Sequencer with the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         lvl_ff       <= '0;
         changed_ff   <= 1'b0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (last_node) begin
                  idx_ff   <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end
            S_IDLE: begin
               if (req_accept) begin
                  rsp_valid_ff <= 1'b1;
                  anc_ff       <= '0;
                  status_ff    <= ST_OK;
                  unique case (req_cmd)
                     CMD_LOAD: begin
                        if (load_ok) begin
                           built_ff <= 1'b0;
                        end
                     end
                     CMD_BUILD: begin
                        rsp_valid_ff <= 1'b0;
                        built_ff     <= 1'b0;
                        idx_ff       <= '0;
                        state_ff     <= S_INIT;
                     end
                     CMD_QUERY: begin
                        if (!built_ff) begin
                           status_ff <= ST_NOT_BUILT;
                        end else if (!query_range_ok) begin
                           status_ff <= ST_DETACHED;
                        end else begin
                           rsp_valid_ff <= 1'b0;
                           a_ff         <= IW'(req_qa);
                           b_ff         <= IW'(req_qb);
                           state_ff     <= S_Q1;
                        end
                     end
                     CMD_NOP: begin
                     end
                  endcase
               end
            end
            // Build: mark the root, then relax depths until a pass adds nothing.
            S_INIT: begin
               if (last_node) begin
                  idx_ff     <= '0;
                  changed_ff <= 1'b0;
                  state_ff   <= S_R0;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end
            S_R0: begin
               state_ff <= S_R1;
            end
            S_R1, S_R2: begin
               if ((state_ff == S_R1) && !(dep_q.known || par_q.none)) begin
                  state_ff <= S_R2;
               end else begin
                  if (state_ff == S_R2 && dep_q.known) begin
                     changed_ff <= 1'b1;
                  end
                  if (last_node) begin
                     idx_ff     <= '0;
                     changed_ff <= 1'b0;
                     if ((state_ff == S_R2) ? relax_more : changed_ff) begin
                        state_ff <= S_R0;
                     end else begin
                        state_ff <= S_Z0;
                     end
                  end else begin
                     idx_ff   <= idx_ff + IW'(1);
                     state_ff <= S_R0;
                  end
               end
            end
            // Level zero of the jump memory from the parents of reached nodes.
            S_Z0: begin
               state_ff <= S_Z1;
            end
            S_Z1: begin
               if (last_node) begin
                  idx_ff <= '0;
                  if (LOG_LEVELS == 1) begin
                     built_ff <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     anc_ff   <= '0;
                     status_ff <= ST_OK;
                     state_ff <= S_IDLE;
                  end else begin
                     lvl_ff   <= LW'(1);
                     state_ff <= S_J0;
                  end
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_Z0;
               end
            end
            // Higher levels: the ancestor of the ancestor one level down.
            S_J0: begin
               state_ff <= S_J1;
            end
            S_J1, S_J2: begin
               if ((state_ff == S_J1) && !jt_qa.none) begin
                  state_ff <= S_J2;
               end else if (last_node) begin
                  idx_ff <= '0;
                  if (last_level) begin
                     built_ff     <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     anc_ff       <= '0;
                     status_ff    <= ST_OK;
                     state_ff     <= S_IDLE;
                  end else begin
                     lvl_ff   <= lvl_ff + LW'(1);
                     state_ff <= S_J0;
                  end
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_J0;
               end
            end
            // Query: connection check and depths.
            S_Q1: begin
               state_ff <= S_Q2;
            end
            S_Q2: begin
               da_ff <= dep_q.depth;
               if (!conn_a || !conn_b) begin
                  rsp_valid_ff <= 1'b1;
                  anc_ff       <= '0;
                  status_ff    <= ST_DETACHED;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_Q3;
               end
            end
            S_Q3: begin
               if (da_ff > dep_q.depth) begin
                  a_ff <= b_ff;
                  b_ff <= a_ff;
                  d_ff <= da_ff - dep_q.depth;
               end else begin
                  d_ff <= dep_q.depth - da_ff;
               end
               state_ff <= S_LT;
            end
            // Lift the deeper node by whole top levels, then by the bits of the difference.
            S_LT: begin
               if (lift_big) begin
                  d_ff     <= IW'(32'(d_ff) - (32'd1 << TOP));
                  state_ff <= S_LTW;
               end else begin
                  lvl_ff   <= '0;
                  state_ff <= S_LB;
               end
            end
            S_LTW: begin
               b_ff     <= jt_qb.node;
               state_ff <= S_LT;
            end
            S_LB: begin
               if (lift_bit) begin
                  state_ff <= S_LBW;
               end else if (last_level) begin
                  state_ff <= S_CMP;
               end else begin
                  lvl_ff <= lvl_ff + LW'(1);
               end
            end
            S_LBW: begin
               b_ff <= jt_qb.node;
               if (last_level) begin
                  state_ff <= S_CMP;
               end else begin
                  lvl_ff   <= lvl_ff + LW'(1);
                  state_ff <= S_LB;
               end
            end
            S_CMP: begin
               if (a_ff == b_ff) begin
                  rsp_valid_ff <= 1'b1;
                  anc_ff       <= NodeW'(a_ff);
                  status_ff    <= ST_OK;
                  state_ff     <= S_IDLE;
               end else begin
                  lvl_ff   <= LW'(TOP);
                  state_ff <= S_CL;
               end
            end
            // Climb both nodes from the top level down while their ancestors differ.
            S_CL: begin
               state_ff <= S_CLW;
            end
            S_CLW: begin
               if (!jt_qa.none && !jt_qb.none && (jt_qa.node != jt_qb.node)) begin
                  a_ff <= jt_qa.node;
                  b_ff <= jt_qb.node;
               end
               if (lvl_ff == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  lvl_ff   <= lvl_ff - LW'(1);
                  state_ff <= S_CL;
               end
            end
            // Single parent steps until the parents agree.
            S_FIN: begin
               state_ff <= S_FINW;
            end
            S_FINW: begin
               if (!jt_qa.none && !jt_qb.none && (jt_qa.node != jt_qb.node)) begin
                  a_ff     <= jt_qa.node;
                  b_ff     <= jt_qb.node;
                  state_ff <= S_FIN;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  anc_ff       <= jt_qa.none ? '0 : NodeW'(jt_qa.node);
                  status_ff    <= jt_qa.none ? ST_DETACHED : ST_OK;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Response word.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - NodeW){1'b0}}, anc_ff};
   assign rsp_tuser  = status_ff;

   // Parents change only during the reset sweep or on a load word.
   assert property (@(posedge clock) disable iff (reset)
      par_we |-> (state_ff == S_CLEAR || state_ff == S_IDLE))
      else $error("parent memory written during build or query");

   // The jump memory is rewritten only while the tables are marked stale.
   assert property (@(posedge clock) disable iff (reset)
      jt_we |-> !built_ff)
      else $error("jump memory written while tables marked built");

   // A not-built answer is only given while the tables are stale.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_NOT_BUILT) |-> !built_ff)
      else $error("not-built status while tables are built");

   // Every failed query carries a zero ancestor.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("non-zero ancestor with error status");

   // A build never answers straight away, so no response follows it at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_cmd == CMD_BUILD) |=> !rsp_tvalid)
      else $error("response raised directly after build accepted");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the binary lifting ancestor core: directed and random words checked by a scoreboard.
`default_nettype none

// Scoreboard: keeps its own copy of the tree and tables and predicts every response word.
class lca_scoreboard;
   localparam int Nodes  = 1024;
   localparam int Levels = 10;
   localparam int NoNode = Nodes;

   typedef struct {
      logic [bllca_pkg::RspDataW-1:0] anc;
      logic [bllca_pkg::StatusW-1:0]  status;
   } rsp_word_type;

   int           parent_of[Nodes];
   int           hop[Levels][Nodes];
   int           level_of[Nodes];
   bit           built;
   rsp_word_type awaited[$];
   int           errors;

   function new();
      for (int i = 0; i < Nodes; i++) begin
         parent_of[i] = NoNode;
         level_of[i]  = 0;
         for (int j = 0; j < Levels; j++) begin
            hop[j][i] = NoNode;
         end
      end
      built  = 0;
      errors = 0;
   endfunction

   // Depths by repeated passes; each pass reaches at least one more generation below the root.
   function void rebuild();
      bit reached[Nodes];
      bit grew;
      for (int i = 0; i < Nodes; i++) begin
         reached[i]  = (i == bllca_pkg::RootNode);
         level_of[i] = 0;
      end
      grew = 1;
      while (grew) begin
         grew = 0;
         for (int i = 0; i < Nodes; i++) begin
            if (!reached[i] && parent_of[i] < Nodes && reached[parent_of[i]]) begin
               reached[i]  = 1;
               level_of[i] = level_of[parent_of[i]] + 1;
               grew        = 1;
            end
         end
      end
      for (int i = 0; i < Nodes; i++) begin
         hop[0][i] = (reached[i] && i != bllca_pkg::RootNode) ? parent_of[i] : NoNode;
      end
      for (int j = 1; j < Levels; j++) begin
         for (int i = 0; i < Nodes; i++) begin
            hop[j][i] = (hop[j-1][i] < Nodes) ? hop[j-1][hop[j-1][i]] : NoNode;
         end
      end
      built = 1;
   endfunction

   function bit attached(int n);
      return n == bllca_pkg::RootNode || hop[0][n] < Nodes;
   endfunction

   // Lift the deeper node, climb both from the top level down, then take single parent steps.
   function int meeting_point(int a, int b);
      int t;
      int d;
      int ua;
      int ub;
      if (level_of[a] > level_of[b]) begin
         t = a; a = b; b = t;
      end
      d = level_of[b] - level_of[a];
      while (d >= (1 << (Levels - 1))) begin
         b = hop[Levels-1][b];
         d -= 1 << (Levels - 1);
      end
      for (int j = 0; j < Levels; j++) begin
         if (d[j]) b = hop[j][b];
      end
      if (a == b) return a;
      for (int j = Levels - 1; j >= 0; j--) begin
         ua = hop[j][a];
         ub = hop[j][b];
         if (ua < Nodes && ub < Nodes && ua != ub) begin
            a = ua; b = ub;
         end
      end
      while (hop[0][a] != hop[0][b] && hop[0][a] < Nodes && hop[0][b] < Nodes) begin
         a = hop[0][a];
         b = hop[0][b];
      end
      return hop[0][a];
   endfunction

   // Note an accepted request word and queue the response it must cause.
   function void note(bllca_pkg::cmd_type cmd, int child, int par, int qa, int qb);
      rsp_word_type w;
      int anc;
      w.anc    = '0;
      w.status = bllca_pkg::ST_OK;
      case (cmd)
         bllca_pkg::CMD_LOAD: begin
            if (child != bllca_pkg::RootNode) begin
               parent_of[child] = par;
               built = 0;
            end
         end
         bllca_pkg::CMD_BUILD: begin
            rebuild();
         end
         bllca_pkg::CMD_QUERY: begin
            if (!built) begin
               w.status = bllca_pkg::ST_NOT_BUILT;
            end else if (!attached(qa) || !attached(qb)) begin
               w.status = bllca_pkg::ST_DETACHED;
            end else begin
               anc = meeting_point(qa, qb);
               if (anc >= Nodes) w.status = bllca_pkg::ST_DETACHED;
               else w.anc = anc[bllca_pkg::RspDataW-1:0];
            end
         end
         default: ;
      endcase
      awaited.insert(awaited.size(), w);
   endfunction

   // Compare a response word with the oldest expectation.
   function void check(logic [bllca_pkg::RspDataW-1:0] anc,
                       logic [bllca_pkg::StatusW-1:0] status, realtime t);
      rsp_word_type w;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected response word anc=%0d status=%0d", t, anc, status);
         errors++;
         return;
      end
      w = awaited.pop_front();
      if (anc !== w.anc) begin
         $display("%0t: ancestor mismatch, expected %0d, actual %0d", t, w.anc, anc);
         errors++;
      end
      if (status !== w.status) begin
         $display("%0t: status mismatch, expected %0d, actual %0d", t, w.status, status);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bllca_pkg::*;

   localparam int CycleLimit = 8000000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic [CmdW-1:0]     req_tuser = CMD_NOP;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic [StatusW-1:0]  rsp_tuser;

   lca_scoreboard sb = new();
   bit            calm = 0;
   bit            long_hold = 0;
   int            cycles = 0;
   int            placed[$];

   binary_lifting_lca_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog on the cycle count.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Response words are checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tuser, $realtime);
   end

   // Receiver: random stall bursts, one long hold-off on request, none at the end.
   initial begin
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one request word from a falling edge and wait until it is taken.
   task automatic send(cmd_type cmd, int child, int par, int qa, int qb);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {qb[9:0], qa[9:0], par[9:0], child[9:0]};
      do @(posedge clock); while (!req_tready);
      sb.note(cmd, child, par, qa, qb);
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
   endtask

   task automatic load(int child, int par);
      send(CMD_LOAD, child, par, 0, 0);
   endtask

   task automatic query(int qa, int qb);
      send(CMD_QUERY, 0, 0, qa, qb);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
   endtask

   function automatic int pick_node();
      if (placed.size() != 0 && $urandom_range(0, 4) != 0)
         return placed[$urandom_range(0, placed.size() - 1)];
      return $urandom_range(0, 1023);
   endfunction

   // One random phase: reshape part of the tree, build, then mostly queries.
   task automatic run_phase(int nloads, int nwords, bit deep_chain);
      int c;
      int p;
      int r;
      if (deep_chain) begin
         load(900, 1);
         for (int k = 901; k < 960; k++) load(k, k - 1);
         for (int k = 900; k < 960; k += 7) placed.insert(placed.size(), k);
      end
      for (int k = 0; k < nloads; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            c = $urandom_range(0, 1023);
            p = $urandom_range(0, 1023);
         end else begin
            c = $urandom_range(2, 1023);
            p = $urandom_range(0, c - 1);
         end
         load(c, p);
         placed.insert(placed.size(), c);
      end
      send(CMD_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023), 0, 0);
      for (int k = 0; k < nwords; k++) begin
         r = $urandom_range(0, 99);
         if (r < 90) query(pick_node(), pick_node());
         else if (r < 96) send(CMD_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 1023));
         else if (r < 97) load($urandom_range(0, 1023), $urandom_range(0, 1023));
         else query($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: no tables yet, unused command, root load, small tree with a cycle.
      query(1, 1);
      send(CMD_NOP, 1023, 1023, 1023, 1023);
      load(1, 5);
      load(2, 1);
      load(3, 2);
      load(4, 2);
      load(0, 1);
      load(1023, 0);
      load(7, 8);
      load(8, 7);
      send(CMD_BUILD, 0, 0, 0, 0);
      query(3, 4);
      query(1023, 3);
      query(1, 1);
      query(3, 3);
      query(2, 3);
      query(7, 3);
      query(3, 500);
      query(0, 1023);
      // A load after a build drops the tables until the next build.
      load(3, 1023);
      query(3, 4);
      send(CMD_BUILD, 0, 0, 0, 0);
      query(3, 4);
      load(1022, 1023);
      placed = '{0, 1, 2, 3, 4, 1022, 1023};

      // Random phases; one with a deep chain, one long receiver hold, one full pause.
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 7) calm = 1;
         if (ph == 2) long_hold = 1;
         if (ph == 4) drain();
         run_phase(60, 160, ph == 3);
      end

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

`default_nettype wire
